[rtl/core/cist_pkg.sv]
package cist_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int USED_W      = $clog2(MAX_ENTRIES + 1);
   localparam int ID_SPACE    = 2048;
   localparam int ID_W        = $clog2(ID_SPACE);
   localparam int FRAME_ID_W  = 16;
   localparam int LEN_W       = 4;
   localparam int MAX_LEN     = 8;
   localparam int PAYLOAD_W   = 64;
   localparam int TIME_W      = 32;
   localparam int HITS_W      = 32;
   localparam int OVF_W       = 32;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int QUEUE_DEPTH = 2;

   // req_tdata layout, lowest bits first
   localparam int REQ_ID_LSB   = 0;
   localparam int REQ_LEN_LSB  = REQ_ID_LSB + FRAME_ID_W;
   localparam int REQ_PL_LSB   = REQ_LEN_LSB + LEN_W;
   localparam int REQ_TIME_LSB = REQ_PL_LSB + PAYLOAD_W;
   localparam int REQ_SLOT_LSB = REQ_TIME_LSB + TIME_W;
   localparam int REQ_BITS     = REQ_SLOT_LSB + SLOT_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // rsp_tdata layout, lowest bits first
   localparam int RSP_ID_LSB   = 0;
   localparam int RSP_LEN_LSB  = RSP_ID_LSB + ID_W;
   localparam int RSP_PL_LSB   = RSP_LEN_LSB + LEN_W;
   localparam int RSP_TIME_LSB = RSP_PL_LSB + PAYLOAD_W;
   localparam int RSP_HITS_LSB = RSP_TIME_LSB + TIME_W;
   localparam int RSP_USED_LSB = RSP_HITS_LSB + HITS_W;
   localparam int RSP_OVF_LSB  = RSP_USED_LSB + USED_W;
   localparam int RSP_BITS     = RSP_OVF_LSB + OVF_W;
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_RECORD = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      OP_RECORD,
      OP_READ,
      OP_CLEAR,
      OP_IGNORE
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_UPDATED    = 3'd0,
      STAT_NEW_SLOT   = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_IGNORED    = 3'd3,
      STAT_READ_OK    = 3'd4,
      STAT_READ_EMPTY = 3'd5,
      STAT_CLEARED    = 3'd6
   } status_type;

   typedef struct packed {
      op_type                op;
      logic [ID_W-1:0]       id;
      logic [LEN_W-1:0]      length;
      logic [PAYLOAD_W-1:0]  payload;
      logic [TIME_W-1:0]     time_ms;
      logic [SLOT_W-1:0]     slot_index;
   } item_type;

   typedef struct packed {
      logic sweep_busy;
   } back_stat_type;

endpackage

[rtl/core/cist_front.sv]
module cist_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // frame_id, length_code, payload, time_ms, slot_index, zero pad
   input  logic [cist_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [cist_pkg::KIND_W-1:0] req_tuser,
   input  cist_pkg::back_stat_type     back_stat,
   output logic                        push_valid,
   input  logic                        push_ready,
   output cist_pkg::item_type          push_item
);
   import cist_pkg::*;

   logic [FRAME_ID_W-1:0] frame_id;
   logic [LEN_W-1:0]      len_raw;
   logic [LEN_W-1:0]      len_clamped;
   logic [PAYLOAD_W-1:0]  payload_raw;
   logic [PAYLOAD_W-1:0]  payload_masked;
   logic                  id_std;

   assign frame_id    = req_tdata[REQ_ID_LSB +: FRAME_ID_W];
   assign len_raw     = req_tdata[REQ_LEN_LSB +: LEN_W];
   assign payload_raw = req_tdata[REQ_PL_LSB +: PAYLOAD_W];
   assign id_std      = (frame_id[FRAME_ID_W-1:ID_W] == '0);
   assign len_clamped = (len_raw > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_raw;

   always_comb begin
      for (int i = 0; i < MAX_LEN; i++) begin
         payload_masked[8*i +: 8] = (LEN_W'(i) < len_clamped) ? payload_raw[8*i +: 8] : 8'd0;
      end
   end

   // no intake while the id map is being swept after reset
   assign req_tready = push_ready && !back_stat.sweep_busy;
   assign push_valid = req_tvalid && !back_stat.sweep_busy;

   always_comb begin
      push_item            = '0;
      push_item.id         = frame_id[ID_W-1:0];
      push_item.length     = len_clamped;
      push_item.payload    = payload_masked;
      push_item.time_ms    = req_tdata[REQ_TIME_LSB +: TIME_W];
      push_item.slot_index = req_tdata[REQ_SLOT_LSB +: SLOT_W];
      unique case (kind_type'(req_tuser))
         KIND_RECORD: push_item.op = id_std ? OP_RECORD : OP_IGNORE;
         KIND_READ:   push_item.op = OP_READ;
         KIND_CLEAR:  push_item.op = OP_CLEAR;
         default:     push_item.op = OP_IGNORE;
      endcase
   end

endmodule

[rtl/core/cist_queue.sv]
module cist_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  cist_pkg::item_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output cist_pkg::item_type pop_item
);
   import cist_pkg::*;

   item_type   entry_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[rtl/core/cist_back.sv]
module cist_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  cist_pkg::item_type                pop_item,
   output cist_pkg::back_stat_type           back_stat,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cist_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [cist_pkg::STATUS_W-1:0]     rsp_tuser
);
   import cist_pkg::*;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOK,
      ST_EXEC
   } state_type;

   // memories
   logic [SLOT_W-1:0]    idmap_mem    [ID_SPACE];
   logic [ID_W-1:0]      slot_id_mem  [MAX_ENTRIES];
   logic [LEN_W-1:0]     slot_len_mem [MAX_ENTRIES];
   logic [PAYLOAD_W-1:0] slot_pl_mem  [MAX_ENTRIES];
   logic [TIME_W-1:0]    slot_time_mem[MAX_ENTRIES];
   logic [HITS_W-1:0]    slot_hits_mem[MAX_ENTRIES];

   logic [SLOT_W-1:0]    map_rd_ff;
   logic [ID_W-1:0]      id_rd_ff;
   logic [LEN_W-1:0]     len_rd_ff;
   logic [PAYLOAD_W-1:0] pl_rd_ff;
   logic [TIME_W-1:0]    time_rd_ff;
   logic [HITS_W-1:0]    hits_rd_ff;

   state_type            state_ff, state_in;
   item_type             cur_ff, cur_in;
   logic [ID_W-1:0]      sweep_cnt_ff, sweep_cnt_in;
   logic                 enable_ff, enable_in;
   logic [USED_W-1:0]    used_ff, used_in;
   logic [OVF_W-1:0]     dropped_ff, dropped_in;
   logic                 out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [RSP_BITS-1:0]  out_data_ff, out_data_in;

   logic                 idmap_we;
   logic [ID_W-1:0]      idmap_wa;
   logic [SLOT_W-1:0]    idmap_wd;
   logic                 slot_we;
   logic                 slot_new;
   logic [SLOT_W-1:0]    slot_wa;
   logic [HITS_W-1:0]    hits_wd;
   logic [SLOT_W-1:0]    slot_ra;
   logic                 exec_go;
   logic                 hit;
   logic                 full;
   logic                 read_ok;
   status_type           status_c;
   logic [ID_W-1:0]      e_id;
   logic [LEN_W-1:0]     e_len;
   logic [PAYLOAD_W-1:0] e_pl;
   logic [TIME_W-1:0]    e_time;
   logic [HITS_W-1:0]    e_hits;

   // a map entry counts only when it points below the fill count at a slot
   // that names the same id, so clearing never has to touch the map
   assign hit     = ({1'b0, map_rd_ff} < used_ff) && (id_rd_ff == cur_ff.id);
   assign full    = (used_ff >= USED_W'(MAX_ENTRIES));
   assign read_ok = ({1'b0, cur_ff.slot_index} < used_ff);
   assign exec_go = (state_ff == ST_EXEC) && (!out_valid_ff || rsp_tready);
   assign slot_ra = (cur_ff.op == OP_READ) ? cur_ff.slot_index : map_rd_ff;

   assign pop_ready            = (state_ff == ST_IDLE);
   assign back_stat.sweep_busy = (state_ff == ST_SWEEP);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sweep_cnt_in = sweep_cnt_ff;
      enable_in    = enable_ff;
      used_in      = used_ff;
      dropped_in   = dropped_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_data_in  = out_data_ff;

      idmap_we = 1'b0;
      idmap_wa = cur_ff.id;
      idmap_wd = used_ff[SLOT_W-1:0];
      slot_we  = 1'b0;
      slot_new = 1'b0;
      slot_wa  = map_rd_ff;
      hits_wd  = hits_rd_ff + HITS_W'(1);
      status_c = STAT_IGNORED;
      e_id     = '0;
      e_len    = '0;
      e_pl     = '0;
      e_time   = '0;
      e_hits   = '0;

      if (csr_wr_en) begin
         enable_in = csr_wr_data;
         if (csr_wr_data && !enable_ff) begin
            used_in    = '0;
            dropped_in = '0;
         end
      end

      unique case (state_ff)
         ST_SWEEP: begin
            idmap_we     = 1'b1;
            idmap_wa     = sweep_cnt_ff;
            idmap_wd     = '0;
            sweep_cnt_in = sweep_cnt_ff + ID_W'(1);
            if (sweep_cnt_ff == ID_W'(ID_SPACE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in   = pop_item;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go) begin
               unique case (cur_ff.op)
                  OP_RECORD: begin
                     if (!enable_ff) begin
                        status_c = STAT_IGNORED;
                     end else if (hit) begin
                        status_c = STAT_UPDATED;
                        slot_we  = 1'b1;
                     end else if (full) begin
                        status_c   = STAT_FULL;
                        dropped_in = dropped_ff + OVF_W'(1);
                     end else begin
                        status_c = STAT_NEW_SLOT;
                        slot_we  = 1'b1;
                        slot_new = 1'b1;
                        slot_wa  = used_ff[SLOT_W-1:0];
                        hits_wd  = HITS_W'(1);
                        idmap_we = 1'b1;
                        used_in  = used_ff + USED_W'(1);
                     end
                  end
                  OP_READ: begin
                     if (read_ok) begin
                        status_c = STAT_READ_OK;
                        e_id     = id_rd_ff;
                        e_len    = len_rd_ff;
                        e_pl     = pl_rd_ff;
                        e_time   = time_rd_ff;
                        e_hits   = hits_rd_ff;
                     end else begin
                        status_c = STAT_READ_EMPTY;
                     end
                  end
                  OP_CLEAR: begin
                     status_c   = STAT_CLEARED;
                     used_in    = '0;
                     dropped_in = '0;
                  end
                  default: begin
                     status_c = STAT_IGNORED;
                  end
               endcase
               out_valid_in  = 1'b1;
               out_status_in = status_c;
               out_data_in   = {dropped_in, used_in, e_hits, e_time, e_pl, e_len, e_id};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_cnt_ff <= '0;
         enable_ff    <= 1'b0;
         used_ff      <= '0;
         dropped_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         enable_ff    <= enable_in;
         used_ff      <= used_in;
         dropped_ff   <= dropped_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff        <= cur_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
   end

   // id map: read at the popped id and held until the item is done,
   // written by the sweep or a new slot
   always_ff @(posedge clock) begin
      if (idmap_we) begin
         idmap_mem[idmap_wa] <= idmap_wd;
      end
      if (pop_ready) begin
         map_rd_ff <= idmap_mem[pop_item.id];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_new) begin
         slot_id_mem[slot_wa] <= cur_ff.id;
      end
      id_rd_ff <= slot_id_mem[slot_ra];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_len_mem[slot_wa]  <= cur_ff.length;
         slot_pl_mem[slot_wa]   <= cur_ff.payload;
         slot_time_mem[slot_wa] <= cur_ff.time_ms;
         slot_hits_mem[slot_wa] <= hits_wd;
      end
      len_rd_ff  <= slot_len_mem[slot_ra];
      pl_rd_ff   <= slot_pl_mem[slot_ra];
      time_rd_ff <= slot_time_mem[slot_ra];
      hits_rd_ff <= slot_hits_mem[slot_ra];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_BITS)'(0), out_data_ff};

endmodule

[rtl/core/can_id_snapshot_table.sv]
// Last-value capture table for standard CAN ids. Each item is one of record,
// read or clear (req_tuser); every item yields exactly one response whose
// status sits in rsp_tuser. Items land in a two-deep queue and are executed
// one at a time, in order: queue pop with the id-map read, slot-table read,
// then update and response register load, which waits while a response is
// stalled. Because of the two dependent memory reads (id map, then slot
// table), a new item is popped only once the last one is done. After reset
// the 2048-entry id map is swept with req_tready held low; csr writes are
// taken throughout. Setting capture_enable from 0 to 1 empties the table.
module can_id_snapshot_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // frame_id[15:0], length_code[19:16], payload[83:20], time_ms[115:84],
   // slot_index[122:116], zero pad
   input  logic [cist_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic [cist_pkg::KIND_W-1:0]       req_tuser,
   input  logic                              csr_wr_en,
   input  logic                              csr_wr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_id[10:0], entry_length[14:11], entry_payload[78:15],
   // entry_time_ms[110:79], entry_hits[142:111], used_slots[150:143],
   // overflow_count[182:151], zero pad
   output logic [cist_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic [cist_pkg::STATUS_W-1:0]     rsp_tuser
);
   import cist_pkg::*;

   back_stat_type back_stat;
   item_type      push_item;
   item_type      pop_item;
   logic          push_valid;
   logic          push_ready;
   logic          pop_valid;
   logic          pop_ready;

   cist_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .back_stat  (back_stat),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   cist_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cist_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_item    (pop_item),
      .back_stat   (back_stat),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule

[rtl/core/cist_checker.sv]
module cist_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [cist_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic [cist_pkg::STATUS_W-1:0]     rsp_tuser
);
   import cist_pkg::*;

   logic [USED_W-1:0] used_slots;
   logic [OVF_W-1:0]  overflow_count;

   assign used_slots     = rsp_tdata[RSP_USED_LSB +: USED_W];
   assign overflow_count = rsp_tdata[RSP_OVF_LSB +: OVF_W];

   // reset drops any pending response
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> used_slots <= USED_W'(MAX_ENTRIES))
      else $error("used_slots beyond table size");

   // slot fields only carry data on a successful read
   a_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STAT_READ_OK) |-> rsp_tdata[RSP_USED_LSB-1:0] == '0)
      else $error("entry fields nonzero outside a read hit");

   a_clear_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_CLEARED) |-> used_slots == '0 && overflow_count == '0)
      else $error("clear left counters nonzero");

endmodule

bind can_id_snapshot_table cist_checker u_cist_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
